// ----- hdl/sscs_pkg.sv -----
// Shared types and constants for the sparse set component store.
package sscs_pkg;

  localparam int ENT_W = 10;
  localparam int CNT_W = 11;
  localparam int ENT_SPAN = 2 ** ENT_W;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ALREADY = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_BEYOND  = 2'd3
  } status_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
    logic look_rd;
    logic look_done;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_look;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/sscs_if.sv -----
// Request and response channel interfaces of the sparse set component store.
interface sscs_req_if #(
  parameter int DATA_WIDTH = 32
) ();
  import sscs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [ENT_W-1:0]      entity;
  logic [DATA_WIDTH-1:0] value;
  logic [ENT_W-1:0]      slot;

  modport source (output valid, output action, output entity, output value, output slot,
                  input ready);
  modport sink (input valid, input action, input entity, input value, input slot,
                output ready);
endinterface

interface sscs_rsp_if #(
  parameter int DATA_WIDTH = 32
) ();
  import sscs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic                  present;
  logic [DATA_WIDTH-1:0] value_out;
  logic [ENT_W-1:0]      owner_out;
  logic [CNT_W-1:0]      member_count;

  modport source (output valid, output status, output present, output value_out,
                  output owner_out, output member_count, input ready);
  modport sink (input valid, input status, input present, input value_out,
                input owner_out, input member_count, output ready);
endinterface

// ----- hdl/sscs_ctrl.sv -----
// Controller state machine: clearing sweep, accept, execute and lookup read.
module sscs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sscs_pkg::stat_t stat,
  output sscs_pkg::cmd_t  cmd
);
  import sscs_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LOOK
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.need_look) begin
          cmd.look_rd = 1'b1;
          state_next  = S_LOOK;
        end else if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LOOK: begin
        if (stat.out_free) begin
          cmd.look_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");
  a_no_load_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !req_ready)
    else $error("transfer accepted during clearing sweep");
  a_look_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.look_rd |=> !req_ready)
    else $error("new transfer accepted before lookup finished");

endmodule

// ----- hdl/sscs_dp.sv -----
// Datapath: sparse map, dense arrays, member count and result register.
module sscs_dp #(
  parameter int MAX_ENTITIES = 1024,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sscs_pkg::cmd_t               cmd,
  output sscs_pkg::stat_t              stat,
  input  logic [1:0]                   action,
  input  logic [sscs_pkg::ENT_W-1:0]   entity,
  input  logic [DATA_WIDTH-1:0]        value,
  input  logic [sscs_pkg::ENT_W-1:0]   slot,
  sscs_rsp_if.source                   rsp
);
  import sscs_pkg::*;

  localparam int DEPTH = (MAX_ENTITIES < ENT_SPAN) ? MAX_ENTITIES : ENT_SPAN;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // storage
  logic                  mem_has [DEPTH];
  logic [AW-1:0]         mem_pos [DEPTH];
  logic [DATA_WIDTH-1:0] mem_val [DEPTH];
  logic [AW-1:0]         mem_own [DEPTH];

  // item and read data
  action_t               act_q;
  logic [AW-1:0]         ent_q;
  logic                  in_range_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CNT_W-1:0]      slot_q;
  logic                  has_rd;
  logic [AW-1:0]         pos_rd;
  logic [DATA_WIDTH-1:0] val_rd;
  logic [AW-1:0]         own_rd;

  // control registers
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [AW-1:0]    clr_idx;
  logic             out_valid;

  // result registers
  status_t               res_status;
  logic                  res_present;
  logic [DATA_WIDTH-1:0] res_value;
  logic [ENT_W-1:0]      res_owner;
  logic [CNT_W-1:0]      res_count;

  logic          member;
  logic          add_ok;
  logic          rem_ok;
  logic          beyond;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] last_idx;
  logic          has_we;
  logic [AW-1:0] has_wa;
  logic          pos_we;
  logic [AW-1:0] pos_wa;
  logic [AW-1:0] pos_wd;
  logic          dns_we;
  logic [AW-1:0] dns_wa;
  logic [DATA_WIDTH-1:0] dns_val_wd;
  logic [AW-1:0] dns_own_wd;
  status_t               st_x;
  logic                  pres_x;
  logic [DATA_WIDTH-1:0] val_x;
  logic [ENT_W-1:0]      own_x;

  assign member   = in_range_q && has_rd;
  assign add_ok   = (act_q == ACT_ADD) && !member && in_range_q && (count != DEPTH_C);
  assign rem_ok   = (act_q == ACT_REMOVE) && member && (count != '0);
  assign beyond   = slot_q >= count;
  assign last_idx = AW'(count - 1'b1);

  assign stat.need_look = (act_q == ACT_LOOKUP) && member;
  assign stat.out_free  = !out_valid || rsp.ready;
  assign stat.clr_last  = (clr_idx == AW'(DEPTH - 1));

  // one shared read address for the dense arrays
  assign rd_en   = cmd.load || cmd.look_rd;
  always_comb begin
    if (cmd.look_rd) rd_addr = pos_rd;
    else if (action_t'(action) == ACT_READ) rd_addr = slot[AW-1:0];
    else rd_addr = last_idx;
  end

  assign has_we = cmd.clear || (cmd.exec && (add_ok || rem_ok));
  assign has_wa = cmd.clear ? clr_idx : ent_q;

  assign pos_we = cmd.exec && (add_ok || rem_ok);
  assign pos_wa = add_ok ? ent_q : own_rd;
  assign pos_wd = add_ok ? count[AW-1:0] : pos_rd;

  assign dns_we     = cmd.exec && (add_ok || rem_ok);
  assign dns_wa     = add_ok ? count[AW-1:0] : pos_rd;
  assign dns_val_wd = add_ok ? val_q : val_rd;
  assign dns_own_wd = add_ok ? ent_q : own_rd;

  always_comb begin
    count_next = count;
    if (cmd.exec && add_ok) count_next = count + 1'b1;
    else if (cmd.exec && rem_ok) count_next = count - 1'b1;
  end

  always_comb begin
    st_x   = ST_OK;
    pres_x = member;
    val_x  = '0;
    own_x  = '0;
    case (act_q)
      ACT_ADD: begin
        pres_x = member || add_ok;
        if (member) st_x = ST_ALREADY;
        else if (!add_ok) st_x = ST_ABSENT;
      end
      ACT_REMOVE: begin
        pres_x = member && !rem_ok;
        if (!rem_ok) st_x = ST_ABSENT;
      end
      ACT_LOOKUP: begin
        st_x = ST_ABSENT;
      end
      ACT_READ: begin
        if (beyond) begin
          st_x = ST_BEYOND;
        end else begin
          val_x = val_rd;
          own_x = ENT_W'(own_rd);
        end
      end
      default: st_x = ST_ABSENT;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (has_we) mem_has[has_wa] <= add_ok && !cmd.clear;
    if (cmd.load) has_rd <= mem_has[entity[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pos_we) mem_pos[pos_wa] <= pos_wd;
    if (cmd.load) pos_rd <= mem_pos[entity[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (dns_we) begin
      mem_val[dns_wa] <= dns_val_wd;
      mem_own[dns_wa] <= dns_own_wd;
    end
    if (rd_en) begin
      val_rd <= mem_val[rd_addr];
      own_rd <= mem_own[rd_addr];
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q      <= action_t'(action);
      ent_q      <= entity[AW-1:0];
      in_range_q <= CNT_W'(entity) < DEPTH_C;
      val_q      <= value;
      slot_q     <= CNT_W'(slot);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.clear) clr_idx <= clr_idx + 1'b1;
      if (cmd.exec || cmd.look_done) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status  <= st_x;
      res_present <= pres_x;
      res_value   <= val_x;
      res_owner   <= own_x;
      res_count   <= count_next;
    end else if (cmd.look_done) begin
      res_status  <= ST_OK;
      res_present <= 1'b1;
      res_value   <= val_rd;
      res_owner   <= '0;
      res_count   <= count;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = res_status;
  assign rsp.present      = res_present;
  assign rsp.value_out    = res_value;
  assign rsp.owner_out    = res_owner;
  assign rsp.member_count = res_count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("member count beyond capacity");
  a_result_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.look_done) |-> (!out_valid || rsp.ready))
    else $error("result register overwritten before transfer");
  a_add_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && add_ok) |=> (count == $past(count) + 1'b1))
    else $error("add did not advance member count");
  a_rem_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && rem_ok) |=> (count == $past(count) - 1'b1))
    else $error("remove did not reduce member count");

endmodule

// ----- hdl/sparse_set_component_store.sv -----
// Top level of the sparse set component store.
//
//   channel  modport  payload
//   req      sink     action, entity, value, slot
//   rsp      source   status, present, value_out, owner_out, member_count
//
// Add, remove and read slot are accepted with map and dense reads, then execute
// with writes; a lookup hit adds a dense read, which waits on the map.
// After reset a sweep clears min(MAX_ENTITIES, 1024) entries of the membership
// memory with req.ready low. The result sits in an output register: the next
// transfer is accepted while it waits, execution stalls until rsp takes it.
module sparse_set_component_store #(
  parameter int MAX_ENTITIES = 1024,
  parameter int DATA_WIDTH   = 32
) (
  input logic        clk,
  input logic        rst,
  sscs_req_if.sink   req,
  sscs_rsp_if.source rsp
);
  import sscs_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  ready;

  sscs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sscs_dp #(
    .MAX_ENTITIES (MAX_ENTITIES),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .action (req.action),
    .entity (req.entity),
    .value  (req.value),
    .slot   (req.slot),
    .rsp    (rsp)
  );

  assign req.ready = ready;

endmodule

// ----- tb/sv/sparse_set_component_store_test.sv -----
// Self-checking testbench for the sparse set component store.
`timescale 1ns / 100ps

import sscs_pkg::*;

localparam int WORD_W = 32;

typedef struct {
  status_t              status;
  logic                 present;
  logic [WORD_W-1:0]    value_out;
  logic [ENT_W-1:0]     owner_out;
  logic [CNT_W-1:0]     member_count;
} store_reply_t;

class store_mirror;
  bit                  member [ENT_SPAN];
  logic [ENT_W-1:0]    pos    [ENT_SPAN];
  logic [WORD_W-1:0]   word   [ENT_SPAN];
  logic [ENT_W-1:0]    owner  [ENT_SPAN];
  int unsigned         filled;
  int unsigned         peak;
  int unsigned         per_action [4];
  int unsigned         per_status [4];
  int unsigned         replies;
  int                  errors;
  store_reply_t        owed [$];

  function void note_request(action_t act, logic [ENT_W-1:0] ent, logic [WORD_W-1:0] val,
                             logic [ENT_W-1:0] slot);
    store_reply_t r;
    int unsigned  idx;
    int unsigned  last;
    logic [ENT_W-1:0] moved;
    r.status    = ST_OK;
    r.value_out = '0;
    r.owner_out = '0;
    case (act)
      ACT_ADD: begin
        if (member[ent]) begin
          r.status = ST_ALREADY;
        end else if (filled >= ENT_SPAN) begin
          r.status = ST_ABSENT;
        end else begin
          pos[ent]      = filled[ENT_W-1:0];
          word[filled]  = val;
          owner[filled] = ent;
          member[ent]   = 1'b1;
          filled++;
        end
      end
      ACT_REMOVE: begin
        if (!member[ent] || filled == 0) begin
          r.status = ST_ABSENT;
        end else begin
          // swap the last dense entry into the freed position
          idx        = 32'(pos[ent]);
          last       = filled - 1;
          moved      = owner[last];
          word[idx]  = word[last];
          owner[idx] = moved;
          pos[moved] = idx[ENT_W-1:0];
          member[ent] = 1'b0;
          filled     = last;
        end
      end
      ACT_LOOKUP: begin
        if (!member[ent]) r.status = ST_ABSENT;
        else r.value_out = word[pos[ent]];
      end
      default: begin
        if (slot >= filled) begin
          r.status = ST_BEYOND;
        end else begin
          r.value_out = word[slot];
          r.owner_out = owner[slot];
        end
      end
    endcase
    r.present      = member[ent];
    r.member_count = filled[CNT_W-1:0];
    if (filled > peak) peak = filled;
    per_action[act]++;
    per_status[r.status]++;
    owed = {owed, r};
  endfunction

  function void compare(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [1:0] status, logic present, logic [WORD_W-1:0] value_out,
                             logic [ENT_W-1:0] owner_out, logic [CNT_W-1:0] member_count);
    store_reply_t e;
    if (owed.size() == 0) begin
      $error("reply transfer with no request outstanding");
      errors++;
      return;
    end
    e = owed.pop_front();
    replies++;
    compare("status", WORD_W'(e.status), WORD_W'(status));
    compare("present", WORD_W'(e.present), WORD_W'(present));
    compare("value_out", e.value_out, value_out);
    compare("owner_out", WORD_W'(e.owner_out), WORD_W'(owner_out));
    compare("member_count", WORD_W'(e.member_count), WORD_W'(member_count));
  endfunction
endclass

module sparse_set_component_store_test;

  localparam int QUIET_LIMIT = 4000;
  localparam int BACKLOG_CYCLES = 300;
  localparam int POOL_N = 24;

  logic clk = 1'b0;
  logic rst;
  bit   no_idle;
  bit   backlog_wanted;
  bit   backlog_done;
  int   quiet = 0;
  logic [ENT_W-1:0] pool [POOL_N];

  store_mirror sb = new();

  sscs_req_if #(.DATA_WIDTH(WORD_W)) req ();
  sscs_rsp_if #(.DATA_WIDTH(WORD_W)) rsp ();

  sparse_set_component_store #(
    .MAX_ENTITIES(ENT_SPAN),
    .DATA_WIDTH  (WORD_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || (backlog_wanted && !backlog_done)) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic issue(action_t act, logic [ENT_W-1:0] ent, logic [WORD_W-1:0] val,
                       logic [ENT_W-1:0] slot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.action <= act;
    req.entity <= ent;
    req.value  <= val;
    req.slot   <= slot;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic pick_and_issue(bit narrow, int add_pct, int rem_pct);
    int r;
    int look_cut;
    int top;
    action_t act;
    logic [ENT_W-1:0] ent;
    logic [ENT_W-1:0] slot;
    look_cut = add_pct + rem_pct + (100 - add_pct - rem_pct) / 2;
    r = $urandom_range(99);
    if (r < add_pct) act = ACT_ADD;
    else if (r < add_pct + rem_pct) act = ACT_REMOVE;
    else if (r < look_cut) act = ACT_LOOKUP;
    else act = ACT_READ;
    if (narrow && $urandom_range(9) < 8) ent = pool[$urandom_range(POOL_N - 1)];
    else ent = ENT_W'($urandom);
    top = sb.filled + 1;
    if (top > ENT_SPAN - 1) top = ENT_SPAN - 1;
    if ($urandom_range(9) < 7) slot = ENT_W'($urandom_range(0, top));
    else slot = ENT_W'($urandom);
    issue(act, ent, $urandom, slot);
  endtask

  // response side: random stalls, one long hold-off on request
  initial begin
    bit want;
    int len;
    rsp.ready = 1'b0;
    forever begin
      if (backlog_wanted && !backlog_done) begin
        want = 1'b0;
        len = BACKLOG_CYCLES;
      end else if (no_idle) begin
        want = 1'b1;
        len = 1;
      end else begin
        want = ($urandom_range(99) < 70);
        if (want) len = $urandom_range(1, 8);
        else if ($urandom_range(99) < 92) len = $urandom_range(1, 3);
        else len = $urandom_range(15, 60);
      end
      rsp.ready <= want;
      repeat (len) @(posedge clk);
      if (len == BACKLOG_CYCLES && !want) backlog_done = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result(rsp.status, rsp.present, rsp.value_out, rsp.owner_out, rsp.member_count);
    if (!rst && req.valid && req.ready)
      sb.note_request(action_t'(req.action), req.entity, req.value, req.slot);
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned order [ENT_SPAN];
    int unsigned tmp;
    int j;
    rst        = 1'b1;
    req.valid  = 1'b0;
    req.action = ACT_ADD;
    req.entity = '0;
    req.value  = '0;
    req.slot   = '0;
    for (int i = 0; i < POOL_N; i++) pool[i] = ENT_W'($urandom);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty store, extreme fields, swap cases and removal of the last entry
    issue(ACT_LOOKUP, '0, '1, '1);
    issue(ACT_REMOVE, '1, '0, '0);
    issue(ACT_READ, '0, '0, '0);
    issue(ACT_READ, '1, '1, '1);
    issue(ACT_ADD, '0, '0, '1);
    issue(ACT_ADD, '1, '1, '0);
    issue(ACT_ADD, '0, 32'h0001_2345, '0);
    issue(ACT_ADD, 10'h2AA, 32'hA5A5_A5A5, 10'h155);
    issue(ACT_ADD, 10'h155, 32'h5A5A_5A5A, 10'h2AA);
    issue(ACT_LOOKUP, '1, $urandom, ENT_W'($urandom));
    issue(ACT_READ, ENT_W'($urandom), $urandom, 10'd0);
    issue(ACT_READ, ENT_W'($urandom), $urandom, 10'd3);
    issue(ACT_READ, ENT_W'($urandom), $urandom, 10'd4);
    issue(ACT_REMOVE, '0, $urandom, ENT_W'($urandom));
    issue(ACT_LOOKUP, 10'h155, $urandom, ENT_W'($urandom));
    issue(ACT_READ, 10'h155, $urandom, 10'd0);
    issue(ACT_REMOVE, 10'h155, $urandom, ENT_W'($urandom));
    issue(ACT_REMOVE, '1, $urandom, ENT_W'($urandom));
    issue(ACT_LOOKUP, '1, $urandom, ENT_W'($urandom));
    issue(ACT_REMOVE, 10'h2AA, $urandom, ENT_W'($urandom));
    issue(ACT_REMOVE, 10'h2AA, $urandom, ENT_W'($urandom));
    issue(ACT_LOOKUP, '0, $urandom, ENT_W'($urandom));

    // churn on a small pool of entities, with a long reply hold-off
    for (int i = 0; i < 160; i++) begin
      if (i == 60) backlog_wanted = 1'b1;
      no_idle = (i >= 110 && i < 140);
      pick_and_issue(1'b1, 40, 25);
    end
    no_idle = 1'b0;

    // fill the store to capacity in shuffled order
    for (int i = 0; i < ENT_SPAN; i++) order[i] = i;
    for (int i = ENT_SPAN - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < ENT_SPAN; i++) begin
      issue(ACT_ADD, ENT_W'(order[i]), $urandom, ENT_W'($urandom));
      if ($urandom_range(7) == 0) pick_and_issue(1'b0, 0, 0);
    end
    issue(ACT_ADD, ENT_W'($urandom), $urandom, ENT_W'($urandom));
    issue(ACT_READ, ENT_W'($urandom), $urandom, '1);
    issue(ACT_LOOKUP, ENT_W'($urandom), $urandom, ENT_W'($urandom));

    // drain with mostly removals over the whole entity range
    for (int i = 0; i < 120; i++) begin
      no_idle = (i >= 40 && i < 80);
      pick_and_issue(1'b0, 15, 50);
    end
    no_idle = 1'b0;
    req.valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d adds, %0d removes, %0d lookups and %0d slot reads; %0d replies.",
             sb.per_action[ACT_ADD], sb.per_action[ACT_REMOVE], sb.per_action[ACT_LOOKUP],
             sb.per_action[ACT_READ], sb.replies);
    $display("Peak membership %0d; replies ok/already/absent/beyond: %0d/%0d/%0d/%0d.",
             sb.peak, sb.per_status[ST_OK], sb.per_status[ST_ALREADY],
             sb.per_status[ST_ABSENT], sb.per_status[ST_BEYOND]);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sscs_pkg.sv
hdl/sscs_if.sv
hdl/sscs_ctrl.sv
hdl/sscs_dp.sv
hdl/sparse_set_component_store.sv
tb/sv/sparse_set_component_store_test.sv
